>>> rtl/lpht_pkg.sv
// Package: shared types and constants for the linear-probe hash table.
`default_nettype none
package lpht_pkg;
  localparam int unsigned SLOTS_DEF      = 256;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned LIMIT_W        = 9;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 9'd179;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_MISSING  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_USED  = 2'd1,
    SL_TOMB  = 2'd2
  } slot_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [7:0]  slot_index;
    logic [8:0]  live_count;
  } rsp_t;
endpackage
`default_nettype wire

>>> rtl/lpht_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/lpht_front.sv
// Front end: accepts requests, classifies the operation, holds a two-entry queue.
`default_nettype none
module lpht_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire lpht_pkg::req_t req_i,
  output logic               q_valid_o,
  output lpht_pkg::req_t     q_req_o,
  output logic               q_legal_o,
  input  wire logic          q_pop_i
);
  lpht_pkg::req_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = ent_q[rd_q];
  assign q_legal_o = (q_req_o.operation == lpht_pkg::OP_SET) ||
                     (q_req_o.operation == lpht_pkg::OP_FIND) ||
                     (q_req_o.operation == lpht_pkg::OP_REMOVE);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= req_i;
  end
endmodule
`default_nettype wire

>>> rtl/lpht_back.sv
// Back end: probe sequencer, slot-state, key and value memories, result register.
`default_nettype none
module lpht_back #(
  parameter int unsigned SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [lpht_pkg::LIMIT_W-1:0]  load_limit_i,
  input  wire logic                          q_valid_i,
  input  wire lpht_pkg::req_t                q_req_i,
  input  wire logic                          q_legal_i,
  output logic                               q_pop_o,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output lpht_pkg::rsp_t                     rsp_o
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DONE  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]   slot_q, slot_d;
  logic [CW-1:0]   n_q, n_d;
  logic            tseen_q, tseen_d;
  logic [AW-1:0]   tomb_q, tomb_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovalid_q, ovalid_d;
  lpht_pkg::rsp_t  out_q, out_d;
  lpht_pkg::rsp_t  res_q, res_d;
  logic [1:0]      op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic                  kwe, vwe;
  logic [AW-1:0]         waddr;
  logic [KEY_BITS-1:0]   krd;
  logic [VALUE_BITS-1:0] vrd;
  logic [1:0]            srd;
  logic                  sst_we;
  lpht_pkg::slot_e       sst_wv;

  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk_i, .we_i(kwe), .waddr_i(waddr), .wdata_i(key_q),
    .raddr_i(slot_q), .rdata_o(krd));
  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_vals (
    .clk_i, .we_i(vwe), .waddr_i(waddr), .wdata_i(val_q),
    .raddr_i(slot_q), .rdata_o(vrd));
  lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_state (
    .clk_i, .we_i(sst_we), .waddr_i(waddr), .wdata_i(sst_wv),
    .raddr_i(slot_q), .rdata_o(srd));

  assign valid_o = ovalid_q;
  assign rsp_o   = out_q;

  logic [CW:0] limit_x, count_x;
  assign limit_x = (CW+1)'(load_limit_i);
  assign count_x = (CW+1)'(count_q);

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    n_d      = n_q;
    tseen_d  = tseen_q;
    tomb_d   = tomb_q;
    count_d  = count_q;
    ovalid_d = ovalid_q && stall_i;
    out_d    = out_q;
    res_d    = res_q;
    q_pop_o  = 1'b0;
    kwe      = 1'b0;
    vwe      = 1'b0;
    waddr    = slot_q;
    sst_we   = 1'b0;
    sst_wv   = lpht_pkg::SL_USED;
    unique case (state_q)
      S_CLEAR: begin
        sst_we = 1'b1;
        sst_wv = lpht_pkg::SL_EMPTY;
        slot_d = slot_q + 1'b1;
        if (slot_q == AW'(SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          slot_d  = q_req_i.hash[AW-1:0];
          n_d     = '0;
          tseen_d = 1'b0;
          tomb_d  = '0;
          state_d = q_legal_i ? S_READ : S_DONE;
          res_d   = '0;
          res_d.status = lpht_pkg::ST_MISSING;
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        state_d = S_DONE;
        if (n_q == CW'(SLOTS) || srd == lpht_pkg::SL_EMPTY) begin
          if (op_q == lpht_pkg::OP_SET) begin
            if (count_x >= limit_x || (n_q == CW'(SLOTS) && !tseen_q)) begin
              res_d.status = lpht_pkg::ST_FULL;
            end else begin
              waddr  = tseen_q ? tomb_q : slot_q;
              kwe    = 1'b1;
              vwe    = 1'b1;
              sst_we = 1'b1;
              count_d = count_q + 1'b1;
              res_d.status     = lpht_pkg::ST_INSERTED;
              res_d.slot_index = 8'(waddr);
            end
          end
        end else if (srd == lpht_pkg::SL_USED && krd == key_q) begin
          res_d.slot_index = 8'(slot_q);
          case (op_q)
            lpht_pkg::OP_SET: begin
              vwe = 1'b1;
              res_d.status = lpht_pkg::ST_UPDATED;
            end
            lpht_pkg::OP_FIND: begin
              res_d.status      = lpht_pkg::ST_FOUND;
              res_d.found_value = 32'(vrd);
            end
            default: begin
              sst_we = 1'b1;
              sst_wv = lpht_pkg::SL_TOMB;
              if (count_q != '0) count_d = count_q - 1'b1;
              res_d.status = lpht_pkg::ST_REMOVED;
            end
          endcase
        end else begin
          if (srd == lpht_pkg::SL_TOMB && !tseen_q) begin
            tseen_d = 1'b1;
            tomb_d  = slot_q;
          end
          slot_d  = slot_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (!ovalid_q || !stall_i) begin
          ovalid_d = 1'b1;
          out_d    = res_q;
          out_d.live_count = 9'(count_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      slot_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    tseen_q <= tseen_d;
    tomb_q  <= tomb_d;
    out_q   <= out_d;
    res_q   <= res_d;
    if (q_pop_o) begin
      op_q  <= q_req_i.operation;
      key_q <= q_req_i.key[KEY_BITS-1:0];
      val_q <= q_req_i.value[VALUE_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// Top level: open-addressing hash table with linear probing and tombstones.
// Usage:
//   Requests (set/find/remove) enter on valid_i/stall_o as a req_t; one result
//   per request leaves on valid_o/stall_i as a rsp_t, in request order.
//   A transfer happens at a clock edge with valid high and stall low.
//   Requests land in a two-entry queue; the probe engine takes them one at a time.
//   Each probed slot takes a registered memory read, then a compare; a request
//   probes 1..SLOTS+1 slots. An unused operation code skips the probing and
//   answers not found. The result sits in an output register; while stall_i
//   is high it holds and the engine waits after finishing its next request;
//   the queue keeps filling. load_limit is written through cfg_we_i/cfg_wdata_i
//   and resets to 179; the user must write it only while idle, which the block
//   does not enforce. After reset a clearing pass marks every slot empty;
//   requests wait in the queue meanwhile. The entry count resets to zero;
//   key/value memories are not cleared.
`default_nettype none
module linear_probe_hash_table #(
  parameter int unsigned SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lpht_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire lpht_pkg::req_t               req_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output lpht_pkg::rsp_t                    rsp_o
);
  logic [lpht_pkg::LIMIT_W-1:0] limit_q;
  logic           q_valid, q_legal, q_pop;
  lpht_pkg::req_t q_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= lpht_pkg::LOAD_LIMIT_RST;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  lpht_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_i,
    .q_valid_o(q_valid), .q_req_o(q_req), .q_legal_o(q_legal), .q_pop_i(q_pop));

  lpht_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i, .rst_ni, .load_limit_i(limit_q),
    .q_valid_i(q_valid), .q_req_i(q_req), .q_legal_i(q_legal), .q_pop_o(q_pop),
    .valid_o, .stall_i, .rsp_o);

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rsp_o.live_count <= 9'(SLOTS)) else $error("live count overflow");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (rsp_o.status == 3'(lpht_pkg::ST_MISSING) ||
                rsp_o.status == 3'(lpht_pkg::ST_FULL)) |->
      rsp_o.slot_index == '0 && rsp_o.found_value == '0)
    else $error("miss result carries data");
endmodule
`default_nettype wire
